/* sv/two_phase_register_memory_cpu_macros.svh */
// Assertion macros used by the two_phase_register_memory_cpu RTL controller.
`ifndef TWO_PHASE_REGISTER_MEMORY_CPU_MACROS_SVH
`define TWO_PHASE_REGISTER_MEMORY_CPU_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TPRMC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tprmc assertion failed");

// Next-cycle implication, disabled during reset.
`define TPRMC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tprmc assertion failed");

`endif

/* sv/tprmc_pkg.sv */
// Package: shared constants, opcodes, controller states and command bundle.
`timescale 1ns / 1ps

package tprmc_pkg;

  // Memory word address width; pages hold four words.
  localparam int MEM_WORD_ADDR_BITS = 12;
  localparam int PAGE_BITS          = MEM_WORD_ADDR_BITS - 2;
  localparam int PAGES              = 1 << PAGE_BITS;
  localparam int WORD_W             = 32;
  localparam int ADDR_FIELD_W       = 24;

  // Control bits in instruction word 0.
  localparam int BIT_A_RAM    = 16;
  localparam int BIT_B_RAM    = 17;
  localparam int BIT_W_RAM    = 18;
  localparam int BIT_W_REG    = 19;
  localparam int BIT_A_CST    = 20;
  localparam int BIT_B_CST    = 21;
  localparam int BIT_ADDR_REG = 22;

  typedef enum logic [3:0] {
    OP_MOV = 4'd0,
    OP_INC = 4'd1,
    OP_ADD = 4'd2,
    OP_NOT = 4'd3,
    OP_NEG = 4'd4,
    OP_SUB = 4'd5,
    OP_XOR = 4'd6,
    OP_OR  = 4'd7,
    OP_AND = 4'd8,
    OP_MUL = 4'd9,
    OP_JIZ = 4'd10,
    OP_JNZ = 4'd11
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_ADDR,
    S_OPA,
    S_OPB,
    S_EXEC,
    S_WB
  } state_t;

  // One command per cycle from controller to datapath.
  typedef struct packed {
    logic load;      // write load word, report
    logic fetch;     // read instruction page at pc
    logic instr_ld;  // capture instruction, read address register
    logic addr_ld;   // form address, read operand page, read A register
    logic opa_ld;    // capture memory word and A register, read B register
    logic opb_ld;    // select operands
    logic exec;      // ALU
    logic wb;        // write back, report
  } cmd_t;

endpackage

/* sv/two_phase_register_memory_cpu.sv */
// Top level: small register/memory CPU, controller plus datapath.
`timescale 1ns / 1ps

// Command-style block. Raise start with operation and load fields valid; the
// transfer happens on the edge where start is high and busy is low. A load
// (operation 0) writes one memory word; busy never rises, so loads can be
// issued every cycle. A step (operation 1) executes the instruction at page
// pc[11:2] and holds busy high through the fetch, address, operand A, operand
// B, execute and write-back states, so no new item is taken until it ends. The
// length is set by the single read port of the register file (address, A and
// B registers are read one per cycle), the two page reads of the word memory
// (instruction, then operand) and the registered ALU stage. Each item produces
// exactly one result, presented for one cycle with done high, the cycle after
// the item's last internal cycle. The receiver cannot stall: results must be
// captured on the done cycle. A new start may be issued in the same cycle done
// is high. Memory words that were never loaded or written read as garbage.
module two_phase_register_memory_cpu (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  logic                                     operation,
  input  logic [tprmc_pkg::MEM_WORD_ADDR_BITS-1:0] load_word_address,
  input  logic [31:0]                              load_data,
  output logic                                     done,
  output logic [31:0]                              program_counter,
  output logic [31:0]                              register_one,
  output logic [31:0]                              alu_result,
  output logic                                     memory_written
);
  import tprmc_pkg::*;

  cmd_t cmd;

  // Sequencer: one state per phase of a step
  tprmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .busy      (busy),
    .cmd       (cmd)
  );

  // Storage, operand muxing, ALU and result registers
  tprmc_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .load_word_address (load_word_address),
    .load_data         (load_data),
    .done              (done),
    .program_counter   (program_counter),
    .register_one      (register_one),
    .alu_result        (alu_result),
    .memory_written    (memory_written)
  );

endmodule

/* sv/tprmc_ctrl.sv */
// Controller: sequences one load or one instruction step through the datapath.
`timescale 1ns / 1ps
`include "two_phase_register_memory_cpu_macros.svh"

module tprmc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            operation,
  output logic            busy,
  output tprmc_pkg::cmd_t cmd
);
  import tprmc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (operation) begin
            cmd.fetch  = 1'b1;
            state_next = S_FETCH;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_FETCH: begin
        cmd.instr_ld = 1'b1;
        state_next   = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr_ld = 1'b1;
        state_next  = S_OPA;
      end
      S_OPA: begin
        cmd.opa_ld = 1'b1;
        state_next = S_OPB;
      end
      S_OPB: begin
        cmd.opb_ld = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        cmd.wb     = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `TPRMC_ASSERT_IMP(a_cmd_onehot0, clk, rst, 1'b1, $onehot0(cmd))
  `TPRMC_ASSERT_NXT(a_load_stays_idle, clk, rst, cmd.load, !busy)
  `TPRMC_ASSERT_NXT(a_fetch_to_wb, clk, rst, cmd.fetch, ##5 cmd.wb)
  `TPRMC_ASSERT_NXT(a_wb_frees, clk, rst, cmd.wb, !busy)

endmodule

/* sv/tprmc_dp.sv */
// Datapath: paged word memory, register file, operand select, ALU, result registers.
`timescale 1ns / 1ps

module tprmc_dp (
  input  logic                                     clk,
  input  logic                                     rst,
  input  tprmc_pkg::cmd_t                          cmd,
  input  logic [tprmc_pkg::MEM_WORD_ADDR_BITS-1:0] load_word_address,
  input  logic [31:0]                              load_data,
  output logic                                     done,
  output logic [31:0]                              program_counter,
  output logic [31:0]                              register_one,
  output logic [31:0]                              alu_result,
  output logic                                     memory_written
);
  import tprmc_pkg::*;

  typedef logic [3:0][WORD_W-1:0] page_t;

  // Word memory, one page per entry, word-granular write.
  page_t                   mem [PAGES];
  page_t                   mem_q;
  logic [PAGE_BITS-1:0]    mem_rd_pg;
  logic                    mem_rd_en;
  logic                    mem_wr_en;
  logic [PAGE_BITS-1:0]    mem_wr_pg;
  logic [1:0]              mem_wr_wd;
  logic [WORD_W-1:0]       mem_wr_data;

  // Register file; entry 0 lives in pc.
  logic [WORD_W-1:0]       rf [16];
  logic [15:0]             rf_vld;
  logic [3:0]              rf_rd_idx;
  logic [WORD_W-1:0]       rf_q;

  logic [WORD_W-1:0]       pc;
  logic [WORD_W-1:0]       r1;
  page_t                   instr;
  logic [MEM_WORD_ADDR_BITS-1:0] widx;
  logic [ADDR_FIELD_W-1:0] addr_full;
  logic [WORD_W-1:0]       mword;
  logic [WORD_W-1:0]       ra;
  logic [WORD_W-1:0]       a_op;
  logic [WORD_W-1:0]       b_op;
  logic [WORD_W-1:0]       result;
  logic [WORD_W-1:0]       alu_val;
  logic [WORD_W-1:0]       pc_plus4;
  logic [3:0]              dest;
  logic                    w_reg;
  logic                    w_ram;

  assign pc_plus4 = pc + 32'd4;
  assign dest     = instr[3][27:24];
  assign w_reg    = instr[0][BIT_W_REG];
  assign w_ram    = instr[0][BIT_W_RAM];

  always_comb begin
    addr_full = instr[0][BIT_ADDR_REG] ? rf_q[ADDR_FIELD_W-1:0]
                                       : instr[3][ADDR_FIELD_W-1:0];
  end

  // Memory port control
  always_comb begin
    mem_rd_en   = cmd.fetch | cmd.addr_ld;
    mem_rd_pg   = cmd.fetch ? pc[MEM_WORD_ADDR_BITS-1:2]
                            : addr_full[MEM_WORD_ADDR_BITS-1:2];
    mem_wr_en   = cmd.load | (cmd.wb & w_ram);
    mem_wr_pg   = cmd.load ? load_word_address[MEM_WORD_ADDR_BITS-1:2]
                           : widx[MEM_WORD_ADDR_BITS-1:2];
    mem_wr_wd   = cmd.load ? load_word_address[1:0] : widx[1:0];
    mem_wr_data = cmd.load ? load_data : result;
  end

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_pg][mem_wr_wd] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      mem_q <= mem[mem_rd_pg];
    end
  end

  // Register file read address per phase
  always_comb begin
    rf_rd_idx = mem_q[3][3:0];
    if (cmd.addr_ld) begin
      rf_rd_idx = instr[1][3:0];
    end else if (cmd.opa_ld) begin
      rf_rd_idx = instr[2][3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rf_rd_idx == 4'd0) begin
      rf_q <= pc;
    end else begin
      rf_q <= rf_vld[rf_rd_idx] ? rf[rf_rd_idx] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
    end else if (cmd.wb && w_reg && dest != 4'd0) begin
      rf_vld[dest] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb && w_reg && dest != 4'd0) begin
      rf[dest] <= result;
    end
  end

  // Operand staging
  always_ff @(posedge clk) begin
    if (cmd.instr_ld) begin
      instr <= mem_q;
    end
    if (cmd.addr_ld) begin
      widx <= addr_full[MEM_WORD_ADDR_BITS-1:0];
    end
    if (cmd.opa_ld) begin
      mword <= mem_q[widx[1:0]];
      ra    <= rf_q;
    end
    if (cmd.opb_ld) begin
      a_op <= instr[0][BIT_A_CST] ? instr[1] : (instr[0][BIT_A_RAM] ? mword : ra);
      b_op <= instr[0][BIT_B_CST] ? instr[2] : (instr[0][BIT_B_RAM] ? mword : rf_q);
    end
    if (cmd.exec) begin
      result <= alu_val;
    end
  end

  // ALU
  always_comb begin
    unique case (op_t'(instr[0][3:0]))
      OP_MOV:  alu_val = a_op;
      OP_INC:  alu_val = a_op + 32'd1;
      OP_ADD:  alu_val = a_op + b_op;
      OP_NOT:  alu_val = ~a_op;
      OP_NEG:  alu_val = 32'd0 - a_op;
      OP_SUB:  alu_val = a_op - b_op;
      OP_XOR:  alu_val = a_op ^ b_op;
      OP_OR:   alu_val = a_op | b_op;
      OP_AND:  alu_val = a_op & b_op;
      OP_MUL:  alu_val = a_op * b_op;
      OP_JIZ:  alu_val = (a_op == 32'd0) ? b_op : pc_plus4;
      OP_JNZ:  alu_val = (a_op != 32'd0) ? b_op : pc_plus4;
      default: alu_val = '0;
    endcase
  end

  // Architectural pc and r1, result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      r1   <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.load | cmd.wb;
      if (cmd.wb) begin
        pc <= (w_reg && dest == 4'd0) ? result : pc_plus4;
        if (w_reg && dest == 4'd1) begin
          r1 <= result;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      alu_result     <= '0;
      memory_written <= 1'b0;
    end else if (cmd.wb) begin
      alu_result     <= result;
      memory_written <= w_ram;
    end
  end

  assign program_counter = pc;
  assign register_one    = r1;

endmodule

/* tb/tb_top.sv */
// Testbench for two_phase_register_memory_cpu: directed and random loads and steps, shadow CPU check.
`timescale 1ns / 1ps

localparam int MEM_AW    = tprmc_pkg::MEM_WORD_ADDR_BITS;
localparam bit ITEM_LOAD = 1'b0;
localparam bit ITEM_STEP = 1'b1;
// first opcode past the defined set; the ALU gives zero for it
localparam logic [3:0] OP_SPARE = 4'd12;

typedef struct {
  logic [31:0] program_counter;
  logic [31:0] register_one;
  logic [31:0] alu_result;
  logic        memory_written;
} cpu_report_t;

// Shadow copy of the CPU: registers, memory, and the reports still owed.
class cpu_shadow;
  logic [31:0] regs [16];
  logic [31:0] mem [1 << MEM_AW];
  bit          written [1 << MEM_AW];
  cpu_report_t reports_due [$];
  int          fails;

  function new();
    foreach (regs[i]) regs[i] = '0;
    foreach (mem[i]) begin
      mem[i] = '0;
      written[i] = 1'b0;
    end
    fails = 0;
  endfunction

  function logic [31:0] alu_eval(logic [3:0] opc, logic [31:0] a, logic [31:0] b,
                                 logic [31:0] pc_next);
    case (opc)
      tprmc_pkg::OP_MOV: return a;
      tprmc_pkg::OP_INC: return a + 32'd1;
      tprmc_pkg::OP_ADD: return a + b;
      tprmc_pkg::OP_NOT: return ~a;
      tprmc_pkg::OP_NEG: return 32'd0 - a;
      tprmc_pkg::OP_SUB: return a - b;
      tprmc_pkg::OP_XOR: return a ^ b;
      tprmc_pkg::OP_OR:  return a | b;
      tprmc_pkg::OP_AND: return a & b;
      tprmc_pkg::OP_MUL: return a * b;
      tprmc_pkg::OP_JIZ: return (a == 32'd0) ? b : pc_next;
      tprmc_pkg::OP_JNZ: return (a != 32'd0) ? b : pc_next;
      default:           return 32'd0;
    endcase
  endfunction

  // Apply one accepted transfer and queue the report it owes.
  function void accept_item(bit op, logic [MEM_AW-1:0] la, logic [31:0] ld);
    cpu_report_t       r;
    logic [31:0]       pc, w0, w1, w2, w3, addr, mword, a, b, pc_next, res;
    logic [MEM_AW-1:0] base, widx;
    logic [3:0]        dest;
    res = '0;
    r.memory_written = 1'b0;
    if (op == ITEM_LOAD) begin
      mem[la] = ld;
      written[la] = 1'b1;
    end else begin
      pc   = regs[0];
      base = {pc[MEM_AW-1:2], 2'b00};
      w0   = mem[base];
      w1   = mem[MEM_AW'(base + 1)];
      w2   = mem[MEM_AW'(base + 2)];
      w3   = mem[MEM_AW'(base + 3)];
      addr = (w0[tprmc_pkg::BIT_ADDR_REG] ? regs[w3[3:0]] : w3) & 32'h00FF_FFFF;
      widx = addr[MEM_AW-1:0];
      mword = mem[widx];
      a = w0[tprmc_pkg::BIT_A_CST] ? w1 : (w0[tprmc_pkg::BIT_A_RAM] ? mword : regs[w1[3:0]]);
      b = w0[tprmc_pkg::BIT_B_CST] ? w2 : (w0[tprmc_pkg::BIT_B_RAM] ? mword : regs[w2[3:0]]);
      pc_next = pc + 32'd4;
      dest = w3[27:24];
      res = alu_eval(w0[3:0], a, b, pc_next);
      if (w0[tprmc_pkg::BIT_W_RAM]) begin
        mem[widx] = res;
        written[widx] = 1'b1;
        r.memory_written = 1'b1;
      end
      if (w0[tprmc_pkg::BIT_W_REG] && dest != 4'd0) regs[dest] = res;
      regs[0] = (w0[tprmc_pkg::BIT_W_REG] && dest == 4'd0) ? res : pc_next;
    end
    r.program_counter = regs[0];
    r.register_one    = regs[1];
    r.alu_result      = res;
    reports_due.insert(reports_due.size(), r);
  endfunction

  function void check_report(logic [31:0] pc, logic [31:0] r1, logic [31:0] alu, logic mw);
    cpu_report_t e;
    if (reports_due.size() == 0) begin
      $error("report with none due: pc %h r1 %h alu %h mw %b", pc, r1, alu, mw);
      fails++;
      return;
    end
    e = reports_due.pop_front();
    if (pc !== e.program_counter) begin
      $error("program_counter: expected %h, actual %h", e.program_counter, pc);
      fails++;
    end
    if (r1 !== e.register_one) begin
      $error("register_one: expected %h, actual %h", e.register_one, r1);
      fails++;
    end
    if (alu !== e.alu_result) begin
      $error("alu_result: expected %h, actual %h", e.alu_result, alu);
      fails++;
    end
    if (mw !== e.memory_written) begin
      $error("memory_written: expected %b, actual %b", e.memory_written, mw);
      fails++;
    end
  endfunction
endclass

module tb_top;

  localparam int ITEM_TARGET = 2000;
  localparam int CYCLE_LIMIT = 400000;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              operation;
  logic [MEM_AW-1:0] load_word_address;
  logic [31:0]       load_data;
  logic              done;
  logic [31:0]       program_counter;
  logic [31:0]       register_one;
  logic [31:0]       alu_result;
  logic              memory_written;

  cpu_shadow shadow = new();
  int        items_sent = 0;
  int        calm_left = 0;
  int        cycles = 0;

  two_phase_register_memory_cpu DUT (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .operation        (operation),
    .load_word_address(load_word_address),
    .load_data        (load_data),
    .done             (done),
    .program_counter  (program_counter),
    .register_one     (register_one),
    .alu_result       (alu_result),
    .memory_written   (memory_written)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Results can't be held off: each done cycle is taken at the edge that ends it.
  // Outputs are read right after the edge, before the block's own updates land.
  always @(posedge clk) begin
    if (!rst && done)
      shadow.check_report(program_counter, register_one, alu_result, memory_written);
  end

  // Hard stop in case the block hangs or stops reporting.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [31:0] ctl(int pos);
    return 32'h1 << pos;
  endfunction

  // One transfer: hold start until the edge with busy low, then idle for a random gap.
  // Called at a rising edge; returns at a rising edge. start gets one NBA per edge.
  task automatic drive_item(bit op, logic [MEM_AW-1:0] la, logic [31:0] ld);
    int gap;
    int roll;
    start <= 1'b1;
    operation <= op;
    load_word_address <= la;
    load_data <= ld;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow.accept_item(op, la, ld);
    items_sent++;
    roll = $urandom_range(0, 99);
    // mostly short gaps, a few long ones, and now and then a run with none
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else if (roll < 2) begin
      calm_left = 60;
      gap = 0;
    end else if (roll < 50) begin
      gap = 0;
    end else if (roll < 85) begin
      gap = $urandom_range(1, 3);
    end else if (roll < 97) begin
      gap = $urandom_range(4, 12);
    end else begin
      gap = $urandom_range(13, 40);
    end
    if (gap > 0) begin
      // junk on the fields while start is low; the block must ignore it
      start <= 1'b0;
      operation <= 1'($urandom_range(0, 1));
      load_word_address <= MEM_AW'($urandom());
      load_data <= $urandom();
      repeat (gap) @(posedge clk);
    end
  endtask

  // Load fields are don't-care on a step, so they carry random bits.
  task automatic run_step();
    drive_item(ITEM_STEP, MEM_AW'($urandom()), $urandom());
  endtask

  task automatic load_page(logic [MEM_AW-1:0] base, logic [31:0] w0, logic [31:0] w1,
                           logic [31:0] w2, logic [31:0] w3);
    drive_item(ITEM_LOAD, base, w0);
    drive_item(ITEM_LOAD, MEM_AW'(base + 1), w1);
    drive_item(ITEM_LOAD, MEM_AW'(base + 2), w2);
    drive_item(ITEM_LOAD, MEM_AW'(base + 3), w3);
  endtask

  // Before a step, load whatever it would read that was never written:
  // the instruction page at pc, then the operand word if A or B comes from memory.
  task automatic prepare_step();
    logic [31:0]       pg [4];
    logic [31:0]       w0, w3, addr;
    logic [MEM_AW-1:0] base, widx;
    base = {shadow.regs[0][MEM_AW-1:2], 2'b00};
    for (int i = 0; i < 4; i++) pg[i] = $urandom();
    // half the constant addresses land in a small data window so data gets reused
    if ($urandom_range(0, 1) == 1) pg[3][11:0] = {6'h3C, pg[3][5:0]};
    // a quarter are branches back into the low code area so code runs again
    if ($urandom_range(0, 3) == 0) begin
      pg[0][3:0] = ($urandom_range(0, 1) == 1) ? tprmc_pkg::OP_JIZ : tprmc_pkg::OP_JNZ;
      pg[0][tprmc_pkg::BIT_W_REG] = 1'b1;
      pg[0][tprmc_pkg::BIT_B_CST] = 1'b1;
      pg[2][11:8] = 4'h0;
      pg[3][27:24] = 4'd0;
    end
    for (int i = 0; i < 4; i++)
      if (!shadow.written[MEM_AW'(base + i)]) drive_item(ITEM_LOAD, MEM_AW'(base + i), pg[i]);
    w0 = shadow.mem[base];
    w3 = shadow.mem[MEM_AW'(base + 3)];
    addr = w0[tprmc_pkg::BIT_ADDR_REG] ? shadow.regs[w3[3:0]] : w3;
    widx = addr[MEM_AW-1:0];
    if (((w0[tprmc_pkg::BIT_A_RAM] && !w0[tprmc_pkg::BIT_A_CST]) ||
         (w0[tprmc_pkg::BIT_B_RAM] && !w0[tprmc_pkg::BIT_B_CST])) && !shadow.written[widx])
      drive_item(ITEM_LOAD, widx, $urandom());
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    operation = 1'b0;
    load_word_address = '0;
    load_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // ---- directed ----
    // load extremes: top and bottom of the address range, all-ones and all-zero data
    drive_item(ITEM_LOAD, '1, 32'hFFFF_FFFF);
    drive_item(ITEM_LOAD, '0, 32'h0000_0000);

    // pc 0: ADD constant all-ones + memory word at a 24-bit address that wraps to the
    // top word; result goes to memory and r1
    load_page(MEM_AW'(0),
              32'(tprmc_pkg::OP_ADD) | ctl(tprmc_pkg::BIT_A_CST) | ctl(tprmc_pkg::BIT_B_RAM) |
              ctl(tprmc_pkg::BIT_W_RAM) | ctl(tprmc_pkg::BIT_W_REG),
              32'hFFFF_FFFF, 32'h0000_0000, 32'h01FF_FFFF);
    run_step();

    // pc 4: JNZ on r1 into register 0, target beyond the memory size so pc wraps
    load_page(MEM_AW'(4),
              32'(tprmc_pkg::OP_JNZ) | ctl(tprmc_pkg::BIT_B_CST) | ctl(tprmc_pkg::BIT_W_REG),
              32'h0000_0001, 32'h0000_1FF0, 32'h0000_0000);
    run_step();

    // landing page: unused opcode, A is register 0 (current pc), address taken from r1,
    // writes the zero result to memory and r2
    load_page(MEM_AW'(12'hFF0),
              32'(OP_SPARE) | ctl(tprmc_pkg::BIT_W_RAM) | ctl(tprmc_pkg::BIT_W_REG) |
              ctl(tprmc_pkg::BIT_ADDR_REG),
              32'h0000_0000, 32'h0000_000F, 32'h0200_0001);
    run_step();

    // next page: NEG of a memory word written by the first step, into r1
    load_page(MEM_AW'(12'hFF4),
              32'(tprmc_pkg::OP_NEG) | ctl(tprmc_pkg::BIT_A_RAM) | ctl(tprmc_pkg::BIT_W_REG),
              32'h0000_0003, 32'h0000_0000, 32'h0100_0FFF);
    run_step();

    // ---- random ----
    // mostly well-formed steps on freshly filled pages, some stray loads as noise
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 15) begin
        drive_item(ITEM_LOAD, MEM_AW'($urandom()), $urandom());
      end else begin
        prepare_step();
        run_step();
      end
    end
    start <= 1'b0;

    // drain: every report in, then a margin for anything stray
    while (shadow.reports_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (shadow.fails == 0 && shadow.reports_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/tprmc_pkg.sv
sv/tprmc_ctrl.sv
sv/tprmc_dp.sv
sv/two_phase_register_memory_cpu.sv
tb/tb_top.sv
